### hdl/longest_distinct_run_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the longest distinct run core.
// Each macro checks one implication on the rising edge of clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef LONGEST_DISTINCT_RUN_CORE_DEFINES_SVH
`define LONGEST_DISTINCT_RUN_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LDR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ldr_pkg.sv
// ---------------------------------------------------------------------------
// ldr_pkg
// Types and constants shared by the longest distinct run core.
// ---------------------------------------------------------------------------
package ldr_pkg;

  // Default sizes of the position counter and of the symbol alphabet.
  localparam int POS_BITS_DEF = 16;
  localparam int ALPHABET_DEF = 256;

  // Number of raw byte codes and width of the reported length.
  localparam int CHAR_CODES = 256;
  localparam int LEN_W      = 16;

  // One input beat: a string byte and its end-of-string mark.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       is_last;
  } in_beat_t;

  // One result beat: the best run length and the overflow mark.
  typedef struct packed {
    logic [LEN_W-1:0] longest;
    logic             overflow;
  } out_beat_t;

  // Write-side commands to the last-position table.
  typedef struct packed {
    logic we;
    logic clear;
  } tbl_cmd_t;

endpackage

### hdl/ldr_table.sv
// ---------------------------------------------------------------------------
// ldr_table
// Last-position table: a synchronous memory of positions, one valid flop
// per symbol, and write-to-read forwarding for back-to-back repeats.
// ---------------------------------------------------------------------------
module ldr_table #(
  parameter int POS_BITS = ldr_pkg::POS_BITS_DEF,
  parameter int ALPHABET = ldr_pkg::ALPHABET_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [$clog2(ALPHABET)-1:0] rd_addr,
  input  ldr_pkg::tbl_cmd_t           cmd,
  input  logic [$clog2(ALPHABET)-1:0] wr_addr,
  input  logic [POS_BITS-1:0]         wr_pos,
  output logic                        entry_valid,
  output logic [POS_BITS-1:0]         entry_pos
);
  import ldr_pkg::*;

  localparam int SYM_W = $clog2(ALPHABET);

  logic [POS_BITS-1:0] mem [ALPHABET];
  logic [POS_BITS-1:0] rd_data;
  logic [SYM_W-1:0]    rd_addr_q;
  logic                fwd_hit;
  logic [POS_BITS-1:0] fwd_pos;
  logic [ALPHABET-1:0] valid_bits;

  // Position memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[wr_addr] <= wr_pos;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      fwd_pos   <= wr_pos;
    end
  end

  // A write landing on the same entry as the read returns the new value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= cmd.we && (wr_addr == rd_addr);
    end
  end

  // Valid flops: set on write, all cleared at the end of a string.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.clear) begin
      valid_bits <= '0;
    end else if (cmd.we) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  // The valid flops are read live so that clears and sets are seen at once.
  assign entry_valid = valid_bits[rd_addr_q];
  assign entry_pos   = fwd_hit ? fwd_pos : rd_data;

endmodule

### hdl/longest_distinct_run_core.sv
// A final byte is held in the compare stage, then its result beat is registered.
// Throughput: one byte per cycle, set by one read and one write of the
// last-position memory per byte, with forwarding for a repeated symbol;
// a final byte waits only while an earlier result beat is stalled.
// Reset (synchronous, active high) clears the string state and valid flops;
// the position memory is not cleared, its entries are masked by valid flops.
// ---------------------------------------------------------------------------
// longest_distinct_run_core
// Streams a string one byte per beat and reports, on the final byte, the
// length of the longest stretch with no repeated byte value.
// ---------------------------------------------------------------------------
`include "longest_distinct_run_core_defines.svh"

module longest_distinct_run_core #(
  parameter int POS_BITS = ldr_pkg::POS_BITS_DEF,
  parameter int ALPHABET = ldr_pkg::ALPHABET_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  ldr_pkg::in_beat_t  byte_beat,
  output logic               result_valid,
  input  logic               result_stall,
  output ldr_pkg::out_beat_t result_beat
);
  import ldr_pkg::*;

  localparam int SYM_W = $clog2(ALPHABET);
  localparam int CMP_W = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Byte code to symbol fold, built at elaboration.
  function automatic logic [CHAR_CODES*SYM_W-1:0] fold_table();
    logic [CHAR_CODES*SYM_W-1:0] t;
    t = '0;
    for (int i = 0; i < CHAR_CODES; i++) begin
      t[i*SYM_W +: SYM_W] = SYM_W'(i % ALPHABET);
    end
    return t;
  endfunction

  localparam logic [CHAR_CODES*SYM_W-1:0] FOLD_TBL = fold_table();

  logic                byte_take;
  logic [SYM_W-1:0]    in_sym;
  logic                s1_valid;
  logic                s1_last;
  logic [SYM_W-1:0]    s1_sym;
  logic                s1_go;
  logic                out_free;
  tbl_cmd_t            tbl_cmd;
  logic                entry_valid;
  logic [POS_BITS-1:0] entry_pos;

  logic [POS_BITS-1:0] position;
  logic [POS_BITS-1:0] window_start;
  logic [LEN_W-1:0]    best_len;
  logic                overflow_flag;

  logic                saturated;
  logic                repeat_hit;
  logic [POS_BITS-1:0] window_start_next;
  logic [POS_BITS-1:0] run_len;
  logic [LEN_W-1:0]    best_next;
  logic                overflow_next;

  // Handshake: the compare stage frees up unless it holds a final byte and a result cannot leave.
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!s1_last || out_free);
  assign byte_stall = s1_valid && !s1_go;
  assign byte_take  = byte_valid && !byte_stall;
  assign in_sym     = FOLD_TBL[byte_beat.char_byte * SYM_W +: SYM_W];

  // Compare stage holds the byte while its table entry is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      s1_last <= byte_beat.is_last;
      s1_sym  <= in_sym;
    end
  end

  ldr_table #(
    .POS_BITS (POS_BITS),
    .ALPHABET (ALPHABET)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (byte_take),
    .rd_addr     (in_sym),
    .cmd         (tbl_cmd),
    .wr_addr     (s1_sym),
    .wr_pos      (position),
    .entry_valid (entry_valid),
    .entry_pos   (entry_pos)
  );

  // Window update, best length and overflow mark for the byte in the compare stage.
  always_comb begin
    saturated         = (position == POS_MAX);
    repeat_hit        = entry_valid && (entry_pos >= window_start);
    window_start_next = repeat_hit ? entry_pos + 1'b1 : window_start;
    run_len           = position - window_start_next + 1'b1;
    best_next         = best_len;
    overflow_next     = overflow_flag;
    if (saturated) begin
      overflow_next     = 1'b1;
      window_start_next = window_start;
    end else if (CMP_W'(run_len) > CMP_W'(best_len)) begin
      best_next = LEN_W'(run_len);
    end
  end

  assign tbl_cmd.we    = s1_go && !saturated;
  assign tbl_cmd.clear = s1_go && s1_last;

  // String state: advance per byte until the position saturates, clear after the final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      window_start  <= '0;
      best_len      <= '0;
      overflow_flag <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        position      <= '0;
        window_start  <= '0;
        best_len      <= '0;
        overflow_flag <= 1'b0;
      end else begin
        position      <= saturated ? position : position + 1'b1;
        window_start  <= window_start_next;
        best_len      <= best_next;
        overflow_flag <= overflow_next;
      end
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      result_beat.longest  <= best_next;
      result_beat.overflow <= overflow_next;
    end
  end

  // Checks on the pipeline and the string state.
  `LDR_ASSERT_SAME(a_stall_needs_item, byte_stall, s1_valid, "stall without a held byte")
  `LDR_ASSERT_NEXT(a_last_emits, s1_go && s1_last, result_valid, "final byte gave no result")
  `LDR_ASSERT_NEXT(a_last_clears, s1_go && s1_last, position == '0 && best_len == '0,
    "string state not cleared after the final byte")
  `LDR_ASSERT_NEXT(a_position_steps, s1_go && !s1_last && !saturated,
    position == $past(position) + 1'b1, "position did not advance")
  `LDR_ASSERT_SAME(a_best_bounded, 1'b1, 32'(best_len) <= 32'(ALPHABET),
    "best length exceeds the alphabet size")

endmodule
